// ===== hw/rtl/pcaz_pkg.sv =====
package pcaz_pkg;

  localparam int ChannelCount = 8;
  localparam int WalkMax = 8;
  localparam logic [3:0] ReinitErrors = 4'd10;
  localparam logic [15:0] CountMax = 16'hFFFF;

  localparam logic [2:0] ActSample = 3'd0;
  localparam logic [2:0] ActPublish = 3'd1;
  localparam logic [2:0] ActZeroStart = 3'd2;
  localparam logic [2:0] ActZeroFinish = 3'd3;
  localparam logic [2:0] ActClearZero = 3'd4;

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindAverage = 2'd1;
  localparam logic [1:0] KindZero = 2'd2;
  localparam logic [1:0] KindCommand = 2'd3;

  localparam logic [1:0] ZstApplied = 2'd0;
  localparam logic [1:0] ZstTooFew = 2'd1;
  localparam logic [1:0] ZstAirflow = 2'd2;

  localparam logic [1:0] RegSignMask = 2'd0;
  localparam logic [1:0] RegActive = 2'd1;
  localparam logic [1:0] RegAirflow = 2'd2;
  localparam logic [1:0] RegMinZero = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic sample;      // apply the input word to its channel
    logic zero_start;
    logic offset_clear;
    logic walk_load;   // latch channel values for walk index
    logic div_start;   // start the divider on the selected operand
    logic div_sel;     // 0 pressure or zero sum, 1 temperature sum
    logic div_zero;    // divide zero sum (zero finish)
    logic pub_apply;   // clear sums of walk channel
    logic zf_apply;    // commit zero finish result
    logic zf_end;      // clear zeroing flag
  } pcaz_cmd_t;

  typedef struct packed {
    logic div_done;
  } pcaz_sts_t;

endpackage

// ===== hw/rtl/pcaz_div.sv =====
module pcaz_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [32:0] quotient
);
  // restoring divider, one bit per cycle
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] rem;
  logic [32:0] q;
  logic [17:0] trial;

  assign trial = {rem, q[32]} - {2'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd33;
        q <= dividend;
        rem <= '0;
      end else if (busy) begin
        if (trial[17]) begin
          rem <= {rem[15:0], q[32]};
          q <= {q[31:0], 1'b0};
        end else begin
          rem <= trial[16:0];
          q <= {q[31:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/pcaz_datapath.sv =====
module pcaz_datapath #(
  parameter int ChanN = pcaz_pkg::ChannelCount,
  parameter int ChW = (ChanN > 1) ? $clog2(ChanN) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  pcaz_pkg::pcaz_cmd_t cmd,
  output pcaz_pkg::pcaz_sts_t sts,
  input  logic [2:0]         walk_idx,
  input  logic [2:0]         in_channel,
  input  logic               in_read_ok,
  input  logic signed [15:0] in_pressure,
  input  logic signed [11:0] in_temperature,
  input  logic [7:0]         sign_mask,
  input  logic [14:0]        airflow_limit,
  output logic               ack_reinit,
  output logic               ack_ok,
  output logic               w_ok,
  output logic               w_has,
  output logic signed [15:0] w_pavg,
  output logic signed [11:0] w_tavg,
  output logic [1:0]         w_zst,
  output logic signed [15:0] w_off,
  output logic [15:0]        w_zcnt
);
  import pcaz_pkg::*;

  logic signed [15:0] offset [ChanN];
  logic signed [31:0] psum [ChanN];
  logic signed [27:0] tsum [ChanN];
  logic [15:0]        scount [ChanN];
  logic [3:0]         ecount [ChanN];
  logic [ChanN-1:0]   okf;
  logic               zactive;
  logic signed [31:0] zsum [ChanN];
  logic [15:0]        zcount [ChanN];

  logic [ChW-1:0] sc;
  logic [ChW-1:0] wc;
  assign sc = ChW'(in_channel);
  assign wc = ChW'(walk_idx);

  // latched walk channel
  logic signed [31:0] l_psum;
  logic signed [27:0] l_tsum;
  logic signed [31:0] l_zsum;
  logic [15:0]        l_scnt;
  logic [15:0]        l_zcnt;

  assign w_zcnt = l_zcnt;

  // sample path
  logic signed [16:0] pa;
  logic signed [17:0] pdiff;
  logic signed [15:0] psat;
  logic [3:0]         enext;
  logic               neg;
  assign neg = sign_mask[in_channel];
  assign pa = neg ? -{in_pressure[15], in_pressure} : {in_pressure[15], in_pressure};
  assign pdiff = {pa[16], pa} - {{2{offset[sc][15]}}, offset[sc]};
  assign psat = (pdiff > 18'sd32767) ? 16'sh7FFF :
                (pdiff < -18'sd32768) ? 16'sh8000 : pdiff[15:0];
  assign enext = ecount[sc] + 4'd1;

  // divider operand
  logic signed [32:0] div_s;
  logic [32:0] mag;
  logic [15:0] dvs;
  logic [32:0] dvd;
  logic [32:0] quo;
  logic        ddone;
  logic        dneg;
  assign div_s = cmd.div_zero ? {l_zsum[31], l_zsum} :
                 cmd.div_sel ? {{5{l_tsum[27]}}, l_tsum} : {l_psum[31], l_psum};
  assign mag = div_s[32] ? -div_s : div_s;
  assign dvs = cmd.div_zero ? l_zcnt : l_scnt;
  assign dvd = mag + {18'd0, dvs[15:1]};

  pcaz_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(dvd),
    .divisor(dvs), .done(ddone), .quotient(quo)
  );
  assign sts.div_done = ddone;

  logic signed [33:0] sq;
  logic signed [15:0] qsat;
  assign sq = dneg ? -{1'b0, quo} : {1'b0, quo};
  assign qsat = (sq > 34'sd32767) ? 16'sh7FFF :
                (sq < -34'sd32768) ? 16'sh8000 : sq[15:0];

  // airflow check, registered product
  logic [30:0] lim_prod;
  logic [32:0] zmag;
  assign zmag = l_zsum[31] ? -{l_zsum[31], l_zsum} : {l_zsum[31], l_zsum};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dneg <= div_s[32];
      lim_prod <= airflow_limit * l_zcnt;
    end
    if (cmd.walk_load) begin
      l_psum <= psum[wc];
      l_tsum <= tsum[wc];
      l_zsum <= zsum[wc];
      l_scnt <= scount[wc];
      l_zcnt <= zcount[wc];
      w_ok <= okf[wc];
      w_has <= scount[wc] != 16'd0;
      w_pavg <= '0;
      w_tavg <= '0;
      w_off <= '0;
      w_zst <= ZstTooFew;
    end
    if (ddone) begin
      if (cmd.div_zero) begin
        w_off <= qsat;
        w_zst <= (zmag > {2'b0, lim_prod}) ? ZstAirflow : ZstApplied;
      end else if (cmd.div_sel) begin
        w_tavg <= qsat[11:0];
      end else begin
        w_pavg <= qsat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zactive <= 1'b0;
      okf <= '0;
      for (int i = 0; i < ChanN; i++) begin
        offset[i] <= '0;
        psum[i] <= '0;
        tsum[i] <= '0;
        scount[i] <= '0;
        ecount[i] <= '0;
        zsum[i] <= '0;
        zcount[i] <= '0;
      end
      ack_reinit <= 1'b0;
      ack_ok <= 1'b0;
    end else begin
      if (cmd.sample) begin
        ack_reinit <= 1'b0;
        if ({2'b0, in_channel} >= 5'(ChanN)) begin
          ack_ok <= 1'b0;
        end else if (!in_read_ok) begin
          if (enext >= ReinitErrors) begin
            ecount[sc] <= '0;
            okf[sc] <= 1'b0;
            ack_reinit <= 1'b1;
            ack_ok <= 1'b0;
          end else begin
            ecount[sc] <= enext;
            ack_ok <= okf[sc];
          end
        end else begin
          ecount[sc] <= '0;
          okf[sc] <= 1'b1;
          ack_ok <= 1'b1;
          if (zactive && zcount[sc] != CountMax) begin
            zsum[sc] <= zsum[sc] + {{15{pa[16]}}, pa};
            zcount[sc] <= zcount[sc] + 16'd1;
          end
          if (scount[sc] != CountMax) begin
            psum[sc] <= psum[sc] + {{16{psat[15]}}, psat};
            tsum[sc] <= tsum[sc] + {{16{in_temperature[11]}}, in_temperature};
            scount[sc] <= scount[sc] + 16'd1;
          end
        end
      end
      if (cmd.zero_start) begin
        zactive <= 1'b1;
        for (int i = 0; i < ChanN; i++) begin
          zsum[i] <= '0;
          zcount[i] <= '0;
        end
      end
      if (cmd.offset_clear) begin
        for (int i = 0; i < ChanN; i++) offset[i] <= '0;
      end
      if (cmd.zf_end) zactive <= 1'b0;
      if (cmd.pub_apply) begin
        psum[wc] <= '0;
        tsum[wc] <= '0;
        scount[wc] <= '0;
      end
      if (cmd.zf_apply && w_zst == ZstApplied) offset[wc] <= w_off;
    end
  end
endmodule

// ===== hw/rtl/pcaz_ctrl.sv =====
module pcaz_ctrl #(
  parameter int ChanN = pcaz_pkg::ChannelCount
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_action,
  input  logic [3:0]          active_channels,
  input  logic [15:0]         zcnt_walk,
  input  logic [15:0]         min_zero_samples,
  input  logic                has_walk,
  output pcaz_pkg::pcaz_cmd_t cmd,
  input  pcaz_pkg::pcaz_sts_t sts,
  output logic [2:0]          walk_idx,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic                last
);
  import pcaz_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_CHECK, S_DIVP, S_DIVT, S_DIVZ, S_EMIT, S_SEND
  } state_t;

  state_t     state;
  logic [3:0] nwalk;
  logic       is_zero;
  logic       started;

  always_comb begin
    nwalk = active_channels;
    if ({1'b0, nwalk} > 5'(ChanN)) nwalk = 4'(ChanN);
    if (nwalk > 4'(WalkMax)) nwalk = 4'(WalkMax);
    if (nwalk == 4'd0) nwalk = 4'd1;
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.sample = in_valid && in_ready && in_action == ActSample;
    cmd.zero_start = in_valid && in_ready && in_action == ActZeroStart;
    cmd.offset_clear = in_valid && in_ready && in_action == ActClearZero;
    cmd.zf_end = in_valid && in_ready && in_action == ActZeroFinish;
    cmd.walk_load = state == S_LOAD;
    cmd.div_zero = is_zero;
    cmd.div_sel = state == S_DIVT;
    cmd.div_start = (state == S_CHECK &&
      (is_zero ? (zcnt_walk != 16'd0 && zcnt_walk >= min_zero_samples) : has_walk)) ||
      (state == S_DIVT && !started);
    cmd.pub_apply = state == S_EMIT && !out_valid && !is_zero;
    cmd.zf_apply = state == S_EMIT && !out_valid && is_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      walk_idx <= '0;
      is_zero <= 1'b0;
      kind <= KindSample;
      last <= 1'b0;
      started <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            walk_idx <= '0;
            if (in_action == ActSample) begin
              kind <= KindSample;
              last <= 1'b1;
              out_valid <= 1'b1;
            end else if (in_action == ActPublish || in_action == ActZeroFinish) begin
              is_zero <= in_action == ActZeroFinish;
              state <= S_LOAD;
            end else begin
              kind <= KindCommand;
              last <= 1'b1;
              out_valid <= 1'b1;
            end
          end
        end
        S_LOAD: state <= S_CHECK;
        S_CHECK: begin
          started <= 1'b0;
          if (cmd.div_start) state <= is_zero ? S_DIVZ : S_DIVP;
          else state <= S_EMIT;
        end
        S_DIVP: begin
          if (sts.div_done) begin
            started <= 1'b0;
            state <= S_DIVT;
          end
        end
        S_DIVT: begin
          // first cycle launches the temperature divide
          if (!started) started <= 1'b1;
          else if (sts.div_done) state <= S_EMIT;
        end
        S_DIVZ: if (sts.div_done) state <= S_EMIT;
        S_EMIT: begin
          if (!out_valid) begin
            kind <= is_zero ? KindZero : KindAverage;
            last <= {1'b0, walk_idx} + 4'd1 == nwalk;
            out_valid <= 1'b1;
            state <= S_SEND;
          end
        end
        S_SEND: begin
          // hold the walk until the word has been taken
          if (out_valid && out_ready) begin
            if (last) state <= S_IDLE;
            else begin
              walk_idx <= walk_idx + 3'd1;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/pressure_channel_averager_zeroing.sv =====
// pressure channel averager with zero-offset calibration
//
// input channel: one word per action (sample, publish, zero start, zero
//   finish, clear zero) on in_valid/in_ready with its own field ports
// output channel: result words on out_valid/out_ready; last marks the final
//   word of an input word
// config: apb-style port, registers at byte addresses 0, 4, 8, 12
//
// ack: sample and command words give their ack in the cycle after accept.
// publish walks the active channels; each channel that holds samples takes
//   two passes through one shared 33-step restoring divider (pressure then
//   temperature); zero finish takes one divider pass per channel that has
//   enough zero samples.
// throughput: one word at a time; a new input word is taken once the
//   previous result word has left the output register.
// reset: all sums, counts, offsets and flags clear; config registers take
//   their documented reset values.
// stall: a waiting result word holds the walk; nothing is dropped.
module pressure_channel_averager_zeroing #(
  parameter int ChanN = pcaz_pkg::ChannelCount
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic [2:0]         channel,
  input  logic               read_ok,
  input  logic signed [15:0] pressure,
  input  logic signed [11:0] temperature,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [2:0]         out_channel,
  output logic               has_data,
  output logic signed [15:0] pressure_avg,
  output logic signed [11:0] temp_avg,
  output logic [1:0]         zero_status,
  output logic signed [15:0] offset_value,
  output logic               reinit_request,
  output logic               sensor_ok,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pcaz_pkg::*;

  // config registers
  logic [7:0]  sign_mask;
  logic [3:0]  active_channels;
  logic [14:0] airflow_limit;
  logic [15:0] min_zero_samples;
  logic [1:0]  reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sign_mask <= '0;
      active_channels <= 4'd8;
      airflow_limit <= 15'd320;
      min_zero_samples <= 16'd10;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegSignMask: sign_mask <= pwdata[7:0];
        RegActive:   active_channels <= pwdata[3:0];
        RegAirflow:  airflow_limit <= pwdata[14:0];
        RegMinZero:  min_zero_samples <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSignMask: prdata = {24'd0, sign_mask};
      RegActive:   prdata = {28'd0, active_channels};
      RegAirflow:  prdata = {17'd0, airflow_limit};
      default:     prdata = {16'd0, min_zero_samples};
    endcase
  end

  pcaz_cmd_t cmd;
  pcaz_sts_t sts;
  logic [2:0] walk_idx;
  logic [1:0] k;
  logic       ack_reinit, ack_ok, w_ok, w_has;
  logic signed [15:0] w_pavg, w_off;
  logic signed [11:0] w_tavg;
  logic [1:0] w_zst;
  logic [2:0] s_chan;
  logic [15:0] w_zcnt;

  // sample channel held for the ack
  always_ff @(posedge clk) begin
    if (cmd.sample) s_chan <= channel;
  end

  pcaz_datapath #(.ChanN(ChanN)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .walk_idx(walk_idx),
    .in_channel(channel), .in_read_ok(read_ok), .in_pressure(pressure),
    .in_temperature(temperature), .sign_mask(sign_mask),
    .airflow_limit(airflow_limit),
    .ack_reinit(ack_reinit), .ack_ok(ack_ok), .w_ok(w_ok), .w_has(w_has),
    .w_pavg(w_pavg), .w_tavg(w_tavg), .w_zst(w_zst), .w_off(w_off),
    .w_zcnt(w_zcnt)
  );

  // zero count of the walk channel gates the zero finish divide
  pcaz_ctrl #(.ChanN(ChanN)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_action(action), .active_channels(active_channels),
    .zcnt_walk(w_zcnt), .min_zero_samples(min_zero_samples),
    .has_walk(w_has), .cmd(cmd), .sts(sts), .walk_idx(walk_idx),
    .out_valid(out_valid), .out_ready(out_ready), .kind(k), .last(last)
  );

  assign kind = k;
  assign out_channel = (k == KindSample) ? s_chan :
                       (k == KindCommand) ? 3'd0 : walk_idx;
  assign has_data = (k == KindAverage) && w_has;
  assign pressure_avg = (k == KindAverage) ? w_pavg : '0;
  assign temp_avg = (k == KindAverage) ? w_tavg : '0;
  assign zero_status = (k == KindZero) ? w_zst : 2'd0;
  assign offset_value = (k == KindZero) ? w_off : '0;
  assign reinit_request = (k == KindSample) && ack_reinit;
  assign sensor_ok = (k == KindSample) ? ack_ok :
                     (k == KindCommand) ? 1'b0 : w_ok;
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pcaz_pkg::*;

  localparam int NCH = 8;
  localparam int WatchLimit = 200000;

  // one input word
  typedef struct packed {
    logic [2:0]         act;
    logic [2:0]         ch;
    logic               ok;
    logic signed [15:0] pres;
    logic signed [11:0] temp;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         ch;
    logic               has;
    logic signed [15:0] pavg;
    logic signed [11:0] tavg;
    logic [1:0]         zst;
    logic signed [15:0] off;
    logic               reinit;
    logic               sok;
    logic               last;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         action = '0;
  logic [2:0]         channel = '0;
  logic               read_ok = 1'b0;
  logic signed [15:0] pressure = '0;
  logic signed [11:0] temperature = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic [2:0]         out_channel;
  logic               has_data;
  logic signed [15:0] pressure_avg;
  logic signed [11:0] temp_avg;
  logic [1:0]         zero_status;
  logic signed [15:0] offset_value;
  logic               reinit_request;
  logic               sensor_ok;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  pressure_channel_averager_zeroing u_dut (.*);

  // predictor copy of the block state and registers
  logic [7:0]  sign_mask_m;
  logic [3:0]  active_m;
  logic [14:0] airflow_m;
  logic [15:0] min_zero_m;
  longint offset_m [NCH];
  longint psum_m [NCH];
  longint tsum_m [NCH];
  int unsigned scount_m [NCH];
  int unsigned errcnt_m [NCH];
  bit okflag_m [NCH];
  bit zeroing_m;
  longint zsum_m [NCH];
  int unsigned zcount_m [NCH];

  in_word_t  pending_words[$];
  res_word_t expected_results[$];

  int  fail_count = 0;
  int  idle_in_pct = 0;
  int  stall_out_pct = 0;
  int  quiet_cycles = 0;
  logic in_acc = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // rounded mean, ties away from zero
  function automatic longint round_mean(input longint s, input longint n);
    longint m;
    longint q;
    m = (s < 0) ? -s : s;
    q = (m + n / 2) / n;
    return (s < 0) ? -q : q;
  endfunction

  function automatic int walk_len();
    int n;
    n = active_m;
    if (n > NCH) n = NCH;
    if (n == 0) n = 1;
    return n;
  endfunction

  function automatic void reset_model();
    sign_mask_m = 8'd0;
    active_m = 4'd8;
    airflow_m = 15'd320;
    min_zero_m = 16'd10;
    zeroing_m = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      offset_m[i] = 0; psum_m[i] = 0; tsum_m[i] = 0; scount_m[i] = 0;
      errcnt_m[i] = 0; okflag_m[i] = 0; zsum_m[i] = 0; zcount_m[i] = 0;
    end
  endfunction

  function automatic res_word_t blank_res();
    res_word_t r;
    r = '0;
    return r;
  endfunction

  // apply one accepted input word and queue the results it causes
  function automatic void predict_word(input in_word_t w);
    res_word_t r;
    longint pa;
    longint s;
    longint mag;
    longint o;
    int c;
    int n;
    c = w.ch;
    r = blank_res();
    r.last = 1'b1;
    case (w.act)
      ActSample: begin
        r.kind = KindSample;
        r.ch = w.ch;
        if (!w.ok) begin
          errcnt_m[c] = (errcnt_m[c] + 1) & 15;
          if (errcnt_m[c] >= ReinitErrors) begin
            // ten misses in a row: ask for a sensor reinit
            errcnt_m[c] = 0;
            okflag_m[c] = 0;
            r.reinit = 1'b1;
          end
          r.sok = okflag_m[c];
        end else begin
          errcnt_m[c] = 0;
          okflag_m[c] = 1;
          pa = w.pres;
          if (sign_mask_m[c]) pa = -pa;
          if (zeroing_m && zcount_m[c] < CountMax) begin
            zsum_m[c] += pa;
            zcount_m[c]++;
          end
          pa = sat16(pa - offset_m[c]);
          if (scount_m[c] < CountMax) begin
            psum_m[c] += pa;
            tsum_m[c] += w.temp;
            scount_m[c]++;
          end
          r.sok = 1'b1;
        end
        expected_results.push_back(r);
      end
      ActPublish: begin
        n = walk_len();
        for (int i = 0; i < n; i++) begin
          r = blank_res();
          r.kind = KindAverage;
          r.ch = 3'(i);
          r.has = scount_m[i] > 0;
          if (r.has) begin
            r.pavg = 16'(round_mean(psum_m[i], scount_m[i]));
            r.tavg = 12'(round_mean(tsum_m[i], scount_m[i]));
          end
          psum_m[i] = 0; tsum_m[i] = 0; scount_m[i] = 0;
          r.sok = okflag_m[i];
          r.last = (i + 1 == n);
          expected_results.push_back(r);
        end
      end
      ActZeroFinish: begin
        zeroing_m = 1'b0;
        n = walk_len();
        for (int i = 0; i < n; i++) begin
          r = blank_res();
          r.kind = KindZero;
          r.ch = 3'(i);
          if (zcount_m[i] == 0 || zcount_m[i] < min_zero_m) begin
            r.zst = ZstTooFew;
          end else begin
            s = zsum_m[i];
            mag = (s < 0) ? -s : s;
            o = sat16(round_mean(s, zcount_m[i]));
            r.off = 16'(o);
            if (mag > longint'(airflow_m) * zcount_m[i]) begin
              r.zst = ZstAirflow;
            end else begin
              r.zst = ZstApplied;
              offset_m[i] = o;
            end
          end
          r.sok = okflag_m[i];
          r.last = (i + 1 == n);
          expected_results.push_back(r);
        end
      end
      default: begin
        if (w.act == ActZeroStart) begin
          zeroing_m = 1'b1;
          for (int i = 0; i < NCH; i++) begin
            zsum_m[i] = 0; zcount_m[i] = 0;
          end
        end else if (w.act == ActClearZero) begin
          for (int i = 0; i < NCH; i++) offset_m[i] = 0;
        end
        r.kind = KindCommand;
        expected_results.push_back(r);
      end
    endcase
  endfunction

  // remembers whether the word on the input was taken at the last edge
  always @(posedge clk) begin
    in_acc <= in_valid && in_ready;
  end

  // driver: feeds words from the pending queue, holds valid until accepted
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_acc) begin
        // hold the word
      end else if (pending_words.size() > 0 && $urandom_range(99, 0) >= idle_in_pct) begin
        in_valid <= 1'b1;
        action <= pending_words[0].act;
        channel <= pending_words[0].ch;
        read_ok <= pending_words[0].ok;
        pressure <= pending_words[0].pres;
        temperature <= pending_words[0].temp;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(99, 0) >= stall_out_pct);
    end
  end

  // monitor: predicts on input accept, checks on output accept
  always @(posedge clk) begin
    res_word_t exp_r;
    in_word_t w;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && in_ready) begin
        w = '{act: action, ch: channel, ok: read_ok, pres: pressure, temp: temperature};
        predict_word(w);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected word kind", kind, -1);
        end else begin
          exp_r = expected_results.pop_front();
          if (kind !== exp_r.kind) report("kind", kind, exp_r.kind);
          if (out_channel !== exp_r.ch) report("out_channel", out_channel, exp_r.ch);
          if (has_data !== exp_r.has) report("has_data", has_data, exp_r.has);
          if (pressure_avg !== exp_r.pavg) report("pressure_avg", pressure_avg, exp_r.pavg);
          if (temp_avg !== exp_r.tavg) report("temp_avg", temp_avg, exp_r.tavg);
          if (zero_status !== exp_r.zst) report("zero_status", zero_status, exp_r.zst);
          if (offset_value !== exp_r.off) report("offset_value", offset_value, exp_r.off);
          if (reinit_request !== exp_r.reinit)
            report("reinit_request", reinit_request, exp_r.reinit);
          if (sensor_ok !== exp_r.sok) report("sensor_ok", sensor_ok, exp_r.sok);
          if (last !== exp_r.last) report("last", last, exp_r.last);
        end
      end
      if (quiet_cycles > WatchLimit) begin
        $display("watchdog: no progress");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // register write through the apb-style port, setup then access
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegSignMask: sign_mask_m = val[7:0];
      RegActive:   active_m = val[3:0];
      RegAirflow:  airflow_m = val[14:0];
      default:     min_zero_m = val[15:0];
    endcase
  endtask

  // wait until the block has drained every queued and expected word
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_word(input logic [2:0] a, input logic [2:0] c, input logic k,
                           input logic signed [15:0] p, input logic signed [11:0] t);
    in_word_t w;
    w = '{act: a, ch: c, ok: k, pres: p, temp: t};
    pending_words.push_back(w);
  endtask

  task automatic push_random_sample(input int range_p);
    logic signed [15:0] p;
    logic signed [11:0] t;
    p = (range_p == 0) ? 16'($urandom) : 16'($signed($urandom_range(2 * range_p, 0)) - range_p);
    t = 12'($signed($urandom_range(2047 + 1024, 0)) - 1024);
    push_word(ActSample, 3'($urandom_range(7, 0)), ($urandom_range(9, 0) != 0), p, t);
  endtask

  // random phase: mostly zeroing sequences and single samples, some publishes and noise
  task automatic random_phase(input int words);
    int r;
    int k;
    k = 0;
    while (k < words) begin
      r = $urandom_range(99, 0);
      if (r < 25) begin
        // well-formed zeroing sequence with small readings
        push_word(ActZeroStart, 3'($urandom), 1'($urandom), 16'($urandom), 12'($urandom));
        for (int i = 0; i < 14; i++) push_random_sample($urandom_range(1, 0) ? 400 : 40);
        push_word(ActZeroFinish, 3'($urandom), 1'($urandom), 16'($urandom), 12'($urandom));
        k += 16;
      end else if (r < 80) begin
        push_random_sample($urandom_range(1, 0) ? 0 : 2000);
        k++;
      end else if (r < 90) begin
        push_word(ActPublish, 3'($urandom), 1'($urandom), 16'($urandom), 12'($urandom));
        k++;
      end else begin
        push_word(3'($urandom_range(7, 2)), 3'($urandom), 1'($urandom), 16'($urandom),
                  12'($urandom));
        k++;
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every action, failed-read run, unknown actions
    push_word(ActSample, 3'd0, 1'b1, 16'sh7FFF, 12'sh7FF);
    push_word(ActSample, 3'd0, 1'b1, 16'sh8000, 12'sh800);
    push_word(ActSample, 3'd7, 1'b1, 16'sh8000, 12'sh000);
    push_word(ActPublish, 3'd0, 1'b0, 16'sh0, 12'sh0);
    for (int i = 0; i < 10; i++) push_word(ActSample, 3'd3, 1'b0, 16'hFFFF, 12'hFFF);
    push_word(ActZeroStart, 3'd0, 1'b0, 16'sh0, 12'sh0);
    for (int i = 0; i < 3; i++) push_word(ActSample, 3'd1, 1'b1, 16'sd20, 12'sd5);
    push_word(ActZeroFinish, 3'd0, 1'b0, 16'sh0, 12'sh0);
    push_word(ActClearZero, 3'd0, 1'b0, 16'sh0, 12'sh0);
    push_word(3'd5, 3'd2, 1'b1, 16'sh1234, 12'sh123);
    push_word(3'd7, 3'd7, 1'b1, 16'hFFFF, 12'hFFF);
    push_word(ActPublish, 3'd0, 1'b0, 16'sh0, 12'sh0);
    drain();

    // config with negation and tight airflow, no idling
    write_reg(RegSignMask, 32'hFF);
    write_reg(RegActive, 32'd8);
    write_reg(RegAirflow, 32'd0);
    write_reg(RegMinZero, 32'd1);
    push_word(ActZeroStart, 3'd0, 1'b0, 16'sh0, 12'sh0);
    push_word(ActSample, 3'd2, 1'b1, 16'sh8000, 12'sh0);
    push_word(ActSample, 3'd4, 1'b1, 16'sh0, 12'sh0);
    push_word(ActZeroFinish, 3'd0, 1'b0, 16'sh0, 12'sh0);
    random_phase(110);
    drain();

    // sender idles most of the time
    idle_in_pct = 66;
    write_reg(RegSignMask, 32'h5A);
    write_reg(RegActive, 32'd1);
    write_reg(RegAirflow, 32'd32767);
    write_reg(RegMinZero, 32'd65535);
    random_phase(110);
    drain();

    // receiver stalls most of the time
    idle_in_pct = 0;
    stall_out_pct = 66;
    write_reg(RegSignMask, 32'h00);
    write_reg(RegActive, 32'd0);
    write_reg(RegAirflow, 32'd320);
    write_reg(RegMinZero, 32'd10);
    random_phase(60);
    // hold off the sender until everything has come back
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    write_reg(RegActive, 32'd15);
    random_phase(60);
    drain();

    // both sides idle a quarter of the time
    idle_in_pct = 25;
    stall_out_pct = 25;
    write_reg(RegSignMask, 32'h81);
    write_reg(RegActive, 32'd5);
    write_reg(RegAirflow, 32'd100);
    write_reg(RegMinZero, 32'd12);
    random_phase(110);
    drain();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
